@@ hdl/msc_pkg.sv @@
// Shared types, constants and helpers for the masked signature scanner.
package msc_pkg;

  localparam int unsigned MAX_PATTERN_DEF   = 16;
  localparam int unsigned HISTORY_DEPTH_DEF = 32;

  localparam int unsigned LEN_W     = 5;
  localparam int unsigned POS_W     = 32;
  localparam int unsigned ADDR_W    = 64;
  localparam int unsigned REL_W     = 32;
  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAT_LO   = 3'd0,
    CFG_PAT_HI   = 3'd1,
    CFG_CARE     = 3'd2,
    CFG_PLEN     = 3'd3,
    CFG_MODE     = 3'd4,
    CFG_REL_OFF  = 3'd5,
    CFG_SEC_BASE = 3'd6
  } cfg_idx_e;

  localparam logic [1:0] ST_FOUND     = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_TRUNCATED = 2'd2;

  localparam logic [7:0] OPC_CALL = 8'hE8;
  localparam logic [7:0] OPC_JMP  = 8'hE9;

  // instruction length of a near call/jmp, and size of the rel32 field
  localparam logic [4:0] BRANCH_ADJ = 5'd5;
  localparam logic [4:0] REL_SIZE   = 5'd4;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] base;
    logic [REL_W-1:0]  rel;
  } res_t;

  function automatic logic [7:0] pat_byte(logic [63:0] lo, logic [63:0] hi, logic [3:0] j);
    logic [127:0] w;
    w = {hi, lo};
    return w[{j, 3'b000} +: 8];
  endfunction

endpackage

@@ hdl/msc_cell.sv @@
// One history cell: holds a section byte and checks the byte moving into it.
module msc_cell (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic [7:0] byte_i,
  input  logic [7:0] pat_i,
  input  logic       care_i,
  output logic [7:0] byte_o,
  output logic       ok_o
);
  logic [7:0] byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else if (en_i) begin
      byte_q <= byte_i;
    end
  end

  // compare on the incoming byte so the match lines up with the shifted window
  assign ok_o   = !care_i || (byte_i == pat_i);
  assign byte_o = byte_q;

endmodule

@@ hdl/msc_out_stage.sv @@
// Two-stage result path: holds the resolved terms, then adds the signed rel32.
module msc_out_stage (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      adv_i,
  input  logic                      res_valid_i,
  input  msc_pkg::res_t             res_i,
  output logic                      out_valid_o,
  output logic [1:0]                status_o,
  output logic [msc_pkg::ADDR_W-1:0] address_o
);
  import msc_pkg::*;

  logic              s1_valid_q;
  res_t              s1_q;
  logic              out_valid_q;
  logic [1:0]        status_q;
  logic [ADDR_W-1:0] addr_q;
  logic [ADDR_W-1:0] rel_ext;

  assign rel_ext = {{(ADDR_W-REL_W){s1_q.rel[REL_W-1]}}, s1_q.rel};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv_i) begin
      s1_valid_q  <= res_valid_i;
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_q     <= res_i;
      status_q <= s1_q.status;
      addr_q   <= s1_q.base + rel_ext;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign address_o   = addr_q;

  a_zero_addr_unless_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_FOUND) |-> address_o == '0)
    else $error("non-found result carries an address");

endmodule

@@ hdl/masked_signature_scan.sv @@
// Result path: a result beat is registered in msc_out_stage (s1, then the output registers).
// Throughput: one section byte per cycle; the history chain shifts one cell per accepted beat.
// Input stalls only while a result beat sits on the output and the sink stalls it.
// Reset: registers to their defaults (pattern length 1), history cleared, scan idle.
// No clearing pass: the block takes bytes from the first cycle after reset.
module masked_signature_scan #(
  parameter int unsigned MAX_PATTERN   = msc_pkg::MAX_PATTERN_DEF,
  parameter int unsigned HISTORY_DEPTH = msc_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration write port
  input  logic                         cfg_we_i,
  input  logic [msc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [63:0]                  cfg_wdata_i,
  // byte stream
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [7:0]                   data_byte_i,
  input  logic                         end_of_section_i,
  // results
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   status_o,
  output logic [msc_pkg::ADDR_W-1:0]   address_o
);
  import msc_pkg::*;

  localparam int unsigned SW = $clog2(HISTORY_DEPTH);  // distance from hit
  localparam int unsigned IW = SW + 1;                 // index arithmetic

  // ---------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------
  logic [63:0]       pat_lo_q, pat_hi_q;
  logic [15:0]       care_q;
  logic [LEN_W-1:0]  plen_q;
  logic              mode_q;
  logic [3:0]        roff_q;
  logic [ADDR_W-1:0] base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q <= '0;
      pat_hi_q <= '0;
      care_q   <= '0;
      plen_q   <= LEN_W'(1);
      mode_q   <= 1'b0;
      roff_q   <= '0;
      base_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PAT_LO:   pat_lo_q <= cfg_wdata_i;
        CFG_PAT_HI:   pat_hi_q <= cfg_wdata_i;
        CFG_CARE:     care_q   <= cfg_wdata_i[15:0];
        CFG_PLEN:     plen_q   <= cfg_wdata_i[LEN_W-1:0];
        CFG_MODE:     mode_q   <= cfg_wdata_i[0];
        CFG_REL_OFF:  roff_q   <= cfg_wdata_i[3:0];
        CFG_SEC_BASE: base_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // Handshake: the whole path advances unless a result beat is held
  // ---------------------------------------------------------------
  logic adv, accept;

  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;
  assign accept     = in_valid_i && adv;

  // ---------------------------------------------------------------
  // Scan state
  // ---------------------------------------------------------------
  logic [POS_W-1:0] cnt_q, hpos_q;
  logic [LEN_W-1:0] fill_q;   // valid history bytes, saturates at MAX_PATTERN
  logic             hit_q, given_q;
  logic [SW-1:0]    since_q;  // distance of the next byte's slot from the hit

  // effective pattern length
  logic [LEN_W-1:0] len;
  assign len = (plen_q > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : plen_q;

  // ---------------------------------------------------------------
  // History chain. h_now[k] is the byte k places back once this beat
  // has shifted in; cell k loads h_now[k].
  // ---------------------------------------------------------------
  logic [7:0] h_now  [HISTORY_DEPTH];
  logic [7:0] cell_q [HISTORY_DEPTH];
  logic [7:0] cpat   [HISTORY_DEPTH];
  logic       ccare  [HISTORY_DEPTH];
  logic       cok    [HISTORY_DEPTH];

  always_comb begin
    logic [LEN_W-1:0] pidx;
    pidx = '0;
    for (int k = 0; k < HISTORY_DEPTH; k++) begin
      // cell k lines up with pattern byte len-1-k
      pidx     = len - LEN_W'(1) - LEN_W'(k);
      cpat[k]  = pat_byte(pat_lo_q, pat_hi_q, pidx[3:0]);
      ccare[k] = (k < MAX_PATTERN) && (LEN_W'(k) < len) && care_q[pidx[3:0]];
    end
  end

  for (genvar k = 0; k < HISTORY_DEPTH; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign h_now[k] = data_byte_i;
    end else begin : g_body
      assign h_now[k] = cell_q[k-1];
    end

    msc_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (accept),
      .byte_i (h_now[k]),
      .pat_i  (cpat[k]),
      .care_i (ccare[k]),
      .byte_o (cell_q[k]),
      .ok_o   (cok[k])
    );
  end

  logic match;
  always_comb begin
    match = 1'b1;
    for (int k = 0; k < HISTORY_DEPTH; k++) begin
      if (!cok[k]) match = 1'b0;
    end
  end

  // ---------------------------------------------------------------
  // Hit detection and resolution
  // ---------------------------------------------------------------
  logic [LEN_W-1:0] fill_new;
  logic             detect, hit_now;
  logic [SW-1:0]    since_now;
  logic [POS_W-1:0] hpos_now;

  assign fill_new  = (fill_q == LEN_W'(MAX_PATTERN)) ? fill_q : fill_q + LEN_W'(1);
  assign detect    = !given_q && !hit_q && (len != '0) && (fill_new >= len) && match;
  assign hit_now   = hit_q || detect;
  assign since_now = hit_q ? since_q : SW'(len - LEN_W'(1));
  assign hpos_now  = hit_q ? hpos_q : cnt_q - POS_W'(len) + POS_W'(1);

  // opcode byte at the hit
  logic [7:0] first;
  always_comb begin
    first = '0;
    for (int k = 0; k < HISTORY_DEPTH; k++) begin
      if (IW'(k) == IW'(since_now)) first = h_now[k];
    end
  end

  logic          need_rel, ready;
  logic [3:0]    rel_at;
  logic [4:0]    adj;
  logic [IW-1:0] wbase;

  always_comb begin
    need_rel = 1'b1;
    rel_at   = '0;
    adj      = '0;
    if (!mode_q) begin
      if ((first == OPC_CALL) || (first == OPC_JMP)) begin
        rel_at = 4'd1;
        adj    = BRANCH_ADJ;
      end else begin
        need_rel = 1'b0;
      end
    end else begin
      rel_at = roff_q;
      adj    = {1'b0, roff_q} + REL_SIZE;
    end
  end

  // all four rel32 bytes are in once the last one has arrived
  assign ready = !need_rel ||
                 (IW'(since_now) >= IW'(rel_at) + IW'(REL_SIZE) - IW'(1));
  assign wbase = IW'(since_now) - IW'(rel_at) - IW'(REL_SIZE) + IW'(1);

  // win[0] is the most significant rel32 byte (latest arrival is nearest)
  logic [7:0] win [4];
  always_comb begin
    for (int m = 0; m < 4; m++) win[m] = '0;
    for (int k = 0; k < HISTORY_DEPTH; k++) begin
      for (int m = 0; m < 4; m++) begin
        if (IW'(k) == wbase + IW'(m)) win[m] = h_now[k];
      end
    end
  end

  logic emit_found, emit_end, res_valid;
  res_t res;

  assign emit_found = !given_q && hit_now && ready;
  assign emit_end   = end_of_section_i && !given_q && !emit_found;
  assign res_valid  = accept && (emit_found || emit_end);

  always_comb begin
    if (emit_found) begin
      res.status = ST_FOUND;
      res.base   = base_q + ADDR_W'(hpos_now) + ADDR_W'(adj);
      // a plain hit carries no displacement
      res.rel    = need_rel ? {win[0], win[1], win[2], win[3]} : '0;
    end else begin
      res.status = hit_now ? ST_TRUNCATED : ST_NOT_FOUND;
      res.base   = '0;
      res.rel    = '0;
    end
  end

  // scan state; a section end returns it to the reset values
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      fill_q  <= '0;
      hit_q   <= 1'b0;
      given_q <= 1'b0;
      hpos_q  <= '0;
      since_q <= '0;
    end else if (accept) begin
      if (end_of_section_i) begin
        cnt_q   <= '0;
        fill_q  <= '0;
        hit_q   <= 1'b0;
        given_q <= 1'b0;
        hpos_q  <= '0;
        since_q <= '0;
      end else begin
        cnt_q   <= cnt_q + POS_W'(1);
        fill_q  <= fill_new;
        hit_q   <= hit_now;
        given_q <= given_q || emit_found;
        hpos_q  <= hpos_now;
        since_q <= since_now + SW'(1);
      end
    end
  end

  // ---------------------------------------------------------------
  // Result path
  // ---------------------------------------------------------------
  msc_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .res_valid_i (res_valid),
    .res_i       (res),
    .out_valid_o (out_valid_o),
    .status_o    (status_o),
    .address_o   (address_o)
  );

  // ---------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------
  a_given_needs_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    given_q |-> hit_q)
    else $error("result marked given without a hit");

  a_pending_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_q && !given_q |-> IW'(since_q) < IW'(HISTORY_DEPTH))
    else $error("pending hit slid out of the history window");

  a_section_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && end_of_section_i |=> !hit_q && !given_q && (cnt_q == '0))
    else $error("scan state not cleared after section end");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= LEN_W'(MAX_PATTERN))
    else $error("fill count beyond pattern capacity");

endmodule

@@ tb/tb_masked_signature_scan.sv @@
// Self-checking testbench for the masked signature scanner: directed and random byte streams.
`timescale 1ns / 100ps

module tb_masked_signature_scan;
  import msc_pkg::*;

  localparam int unsigned HIST         = HISTORY_DEPTH_DEF;
  localparam int unsigned MAXP         = MAX_PATTERN_DEF;
  localparam int unsigned RESET_CYCLES = 9;
  // result beat trails its byte through the registered output stages; leave a margin before touching registers
  localparam int unsigned SETTLE_PAD   = 4;
  localparam int unsigned HOLD_CYCLES  = 150;
  localparam int unsigned RANDOM_ITEMS = 1300;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  typedef struct {
    logic [1:0]  status;
    logic [63:0] address;
  } scan_result_t;

  // sink back-pressure styles
  typedef enum int unsigned {RX_FREE, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_e;

  // Scoreboard: shadow registers, shadow scan state and the queue of results still owed.
  class scan_scoreboard;
    logic [63:0]  pat_lo, pat_hi, base;
    logic [15:0]  care;
    logic [4:0]   plen;
    logic         mode;
    logic [3:0]   rel_off;
    logic [7:0]   window [HIST];
    logic [31:0]  byte_pos, hit_pos;
    bit           hit_seen, result_given;
    int unsigned  fill;
    scan_result_t due_results [$];
    int unsigned  errors;

    function new();
      pat_lo  = '0;
      pat_hi  = '0;
      base    = '0;
      care    = '0;
      plen    = 5'd1;
      mode    = 1'b0;
      rel_off = '0;
      errors  = 0;
      foreach (window[k]) window[k] = 8'h00;
      clear_scan();
    endfunction

    function void clear_scan();
      byte_pos     = '0;
      hit_pos      = '0;
      hit_seen     = 1'b0;
      result_given = 1'b0;
      fill         = 0;
    endfunction

    // byte that came 'back' beats before the newest one
    function logic [7:0] older(logic [31:0] back);
      if (back >= HIST) return 8'h00;
      return window[back];
    endfunction

    function void set_reg(cfg_idx_e idx, logic [63:0] v);
      case (idx)
        CFG_PAT_LO:   pat_lo  = v;
        CFG_PAT_HI:   pat_hi  = v;
        CFG_CARE:     care    = v[15:0];
        CFG_PLEN:     plen    = v[4:0];
        CFG_MODE:     mode    = v[0];
        CFG_REL_OFF:  rel_off = v[3:0];
        CFG_SEC_BASE: base    = v;
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return due_results.size();
    endfunction

    // Accepted byte beat: advance the shadow scan and queue any result it completes.
    function void note_byte(logic [7:0] b, logic eos);
      logic [31:0]  cur, since, rel_at, rel;
      logic [63:0]  addr;
      logic [127:0] pat;
      logic [7:0]   opc;
      int unsigned  len;
      bit           hit_now, ready;
      scan_result_t r;
      cur = byte_pos;
      len = (plen > 5'(MAXP)) ? MAXP : 32'(plen);
      pat = {pat_hi, pat_lo};
      for (int k = HIST - 1; k > 0; k--) window[k] = window[k-1];
      window[0] = b;
      if (fill < HIST) fill++;
      byte_pos = cur + 32'd1;

      // masked compare over the newest len bytes; zero length never hits
      if (!result_given && !hit_seen && len > 0 && fill >= len) begin
        hit_now = 1'b1;
        for (int j = 0; j < len; j++) begin
          if (care[j] && older(32'(len - 1 - j)) != pat[j*8 +: 8]) hit_now = 1'b0;
        end
        if (hit_now) begin
          hit_seen = 1'b1;
          hit_pos  = cur - 32'(len - 1);
        end
      end

      if (!result_given && hit_seen) begin
        since  = cur - hit_pos;
        opc    = older(since);
        addr   = base + {32'h0, hit_pos};
        rel_at = '0;
        ready  = 1'b0;
        if (mode == 1'b0) begin
          if (opc == OPC_CALL || opc == OPC_JMP) begin
            rel_at = 32'd1;
            addr   = addr + 64'(BRANCH_ADJ);
          end else begin
            ready = 1'b1;   // plain hit, no displacement to fetch
          end
        end else begin
          rel_at = 32'(rel_off);
          addr   = addr + 64'(rel_off) + 64'(REL_SIZE);
        end
        if (!ready && since >= rel_at + 32'd3) begin
          rel = {older(since - rel_at - 32'd3), older(since - rel_at - 32'd2),
                 older(since - rel_at - 32'd1), older(since - rel_at)};
          addr  = addr + {{32{rel[31]}}, rel};
          ready = 1'b1;
        end
        if (ready) begin
          r.status     = ST_FOUND;
          r.address    = addr;
          due_results  = {due_results, r};
          result_given = 1'b1;
        end
      end

      if (eos) begin
        if (!result_given) begin
          r.status    = hit_seen ? ST_TRUNCATED : ST_NOT_FOUND;
          r.address   = '0;
          due_results = {due_results, r};
        end
        clear_scan();   // history survives the section boundary
      end
    endfunction

    function void check_result(logic [1:0] st, logic [63:0] ad);
      scan_result_t want;
      if (due_results.size() == 0) begin
        $display("%0t: result beat with nothing owed: status %0d address %h", $time, st, ad);
        errors++;
        return;
      end
      want = due_results.pop_front();
      if (st !== want.status) begin
        $display("%0t: status mismatch: expected %0d actual %0d", $time, want.status, st);
        errors++;
      end
      if (ad !== want.address) begin
        $display("%0t: address mismatch: expected %h actual %h", $time, want.address, ad);
        errors++;
      end
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // DUT hookup. Every input has a known value from time zero.
  // ---------------------------------------------------------------------------
  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx   = '0;
  logic [63:0]          cfg_wdata = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  logic [7:0]           in_byte   = '0;
  logic                 in_eos    = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [1:0]           status;
  logic [ADDR_W-1:0]    address;

  scan_scoreboard sb = new();

  int unsigned bytes_sent = 0;
  int unsigned burst_left = 0;
  bit          hold_req   = 1'b0;

  masked_signature_scan u_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .data_byte_i      (in_byte),
    .end_of_section_i (in_eos),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .status_o         (status),
    .address_o        (address)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Driver tasks. All run just after a rising edge and drive with NBAs, so the
  // DUT sees the new values at the next edge and handshakes are sampled pre-edge.
  // ---------------------------------------------------------------------------

  // One byte beat. Valid stays up across a burst; a burst ends in a random gap.
  task automatic send_byte(logic [7:0] b, logic eos);
    int unsigned gap;
    in_valid <= 1'b1;
    in_byte  <= b;
    in_eos   <= eos;
    do @(posedge clk); while (in_stall);
    sb.note_byte(b, eos);
    bytes_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      // now and then a long unbroken stretch, otherwise short bursts
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(0, 20);
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_section(input logic [7:0] bytes_q [$], input bit close);
    foreach (bytes_q[i]) send_byte(bytes_q[i], close && (i == bytes_q.size() - 1));
  endtask

  // Sender pauses until every owed result has been seen, then lets the pipe empty.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_PAD) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [63:0] v);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    sb.set_reg(idx, v);
  endtask

  // Back-to-back writes of the whole register file; called after settle(), maybe with a section open.
  task automatic set_all(logic [63:0] lo, logic [63:0] hi, logic [15:0] care,
                         logic [4:0] plen, logic mode, logic [3:0] off, logic [63:0] base);
    write_reg(CFG_PAT_LO,   lo);
    write_reg(CFG_PAT_HI,   hi);
    write_reg(CFG_CARE,     64'(care));
    write_reg(CFG_PLEN,     64'(plen));
    write_reg(CFG_MODE,     64'(mode));
    write_reg(CFG_REL_OFF,  64'(off));
    write_reg(CFG_SEC_BASE, base);
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result sink: checks each taken beat, then picks next cycle's stall.
  // A hold-off request parks the sink with its stall held up, so the block backs up.
  // ---------------------------------------------------------------------------
  initial begin : sink
    int unsigned hold_left;
    int unsigned mode_left;
    rx_mode_e    rx_mode;
    hold_left = 0;
    mode_left = 0;
    rx_mode   = RX_FREE;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) sb.check_result(status, address);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (mode_left == 0) begin
        rx_mode   = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 80);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (rx_mode)
          RX_FREE:  out_stall <= 1'b0;
          RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default:  out_stall <= ~out_stall;
        endcase
      end
    end
  end

  // Watchdog
  initial begin : watchdog
    int unsigned cycles_run;
    cycles_run = 0;
    while (cycles_run < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles_run++;
    end
    $display("masked_signature_scan regression: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [7:0]   sect [$];
    logic [63:0]  lo, hi, base;
    logic [127:0] pat;
    logic [15:0]  care;
    logic [4:0]   plen;
    logic         mode;
    logic [3:0]   off;
    int unsigned  len, goal, phase, kind, tail;
    bit           open_end;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed ---
    // reset registers: length 1, all wildcard, branch mode -> call at byte 0
    sect = '{OPC_CALL, 8'h01, 8'h02, 8'h03, 8'h04};
    send_section(sect, 1'b1);

    // jmp with wildcard second byte, rel32 of -1, base near the top so the sum wraps
    settle();
    set_all({56'h0, OPC_JMP}, '1, 16'h0001, 5'd2, 1'b0, 4'd0, 64'hFFFF_FFFF_FFFF_FFF0);
    sect = '{8'h00, OPC_JMP, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_section(sect, 1'b1);

    // non-branch hit gives the hit address; the trailing byte must stay silent
    settle();
    set_all(64'h55, '0, 16'h0001, 5'd1, 1'b0, 4'd0, 64'h1000);
    sect = '{8'h00, 8'h55, 8'h77};
    send_section(sect, 1'b1);

    // call whose rel32 runs off the section end
    settle();
    set_all({56'h0, OPC_CALL}, '0, 16'h0001, 5'd1, 1'b0, 4'd0, 64'h1000);
    sect = '{OPC_CALL, 8'h11};
    send_section(sect, 1'b1);

    // zero length never matches
    settle();
    set_all('0, '0, 16'h0000, 5'd0, 1'b0, 4'd0, '0);
    sect = '{8'hAA, 8'hBB};
    send_section(sect, 1'b1);

    // static mode, negative displacement two bytes after the hit
    settle();
    set_all('1, '1, 16'h0000, 5'd1, 1'b1, 4'd2, '1);
    sect = '{8'h48, 8'h8B, 8'h10, 8'h20, 8'h30, 8'hF0};
    send_section(sect, 1'b1);

    // --- random phases: fresh registers each phase, mostly planted patterns ---
    phase = 0;
    goal  = bytes_sent + RANDOM_ITEMS;
    while (bytes_sent < goal) begin
      case (phase)
        0: begin   // everything at its top value; length 31 saturates to 16
          lo = '1; hi = '1; care = '1; plen = 5'd31; mode = 1'b1; off = 4'd15; base = '1;
        end
        1: begin   // everything but the length at the bottom, full-width wildcard pattern
          lo = '0; hi = '0; care = '0; plen = 5'd16; mode = 1'b0; off = 4'd0; base = '0;
        end
        default: begin
          lo = {32'($urandom), 32'($urandom)};
          hi = {32'($urandom), 32'($urandom)};
          case ($urandom_range(0, 3))
            0:       lo[7:0] = OPC_CALL;
            1:       lo[7:0] = OPC_JMP;
            default: ;
          endcase
          case ($urandom_range(0, 5))
            0:       care = '0;
            1:       care = '1;
            default: care = 16'($urandom);
          endcase
          kind = $urandom_range(0, 19);
          if (kind == 0)      plen = 5'd0;
          else if (kind > 16) plen = 5'($urandom_range(17, 31));
          else                plen = 5'(kind);
          mode = 1'($urandom);
          off  = 4'($urandom);
          base = ($urandom_range(0, 5) == 0) ? '1 : {32'($urandom), 32'($urandom)};
        end
      endcase
      // the previous phase may have left a section open: registers change mid-scan
      settle();
      set_all(lo, hi, care, plen, mode, off, base);
      // one long sink hold-off while the sender keeps pushing
      if (phase == 3) hold_req = 1'b1;

      len = (plen > 5'(MAXP)) ? MAXP : 32'(plen);
      pat = {hi, lo};
      kind = bytes_sent + $urandom_range(60, 140);   // phase end
      while (bytes_sent < kind) begin
        sect.delete();
        if ($urandom_range(0, 9) < 2 || len == 0) begin
          repeat ($urandom_range(1, 16)) sect = {sect, 8'($urandom)};
        end else begin
          repeat ($urandom_range(0, 12)) sect = {sect, 8'($urandom)};
          // cared bytes from the pattern, wildcards mostly random
          for (int j = 0; j < len; j++) begin
            if (care[j] || $urandom_range(0, 3) == 0) sect = {sect, pat[j*8 +: 8]};
            else sect = {sect, 8'($urandom)};
          end
          tail = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : $urandom_range(0, 24);
          repeat (tail) sect = {sect, 8'($urandom)};
        end
        open_end = (bytes_sent + sect.size() >= kind) && ($urandom_range(0, 3) == 0);
        send_section(sect, !open_end);
      end
      phase++;
    end

    // drain and give the pipe a last margin before the verdict
    settle();
    repeat (2 * SETTLE_PAD) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("masked_signature_scan regression: pass");
    end else begin
      $display("masked_signature_scan regression: fail");
    end
    $finish;
  end

endmodule
